@@ rtl/atrp_pkg.sv @@
// Shared constants, types and the quadrant pre-rotation for the tilt pipeline.
`timescale 1ns / 1ps

package atrp_pkg;

	// Square-root datapath: 64-bit radicand, 32-bit root, one root bit per cell
	localparam int RAD_W  = 64;
	localparam int ROOT_W = 32;

	// CORDIC datapath: vector components and Q30 angle accumulator
	localparam int VEC_W    = 64;
	localparam int Z_W      = 34;
	localparam int PRESCALE = 27;

	localparam logic signed [63:0] PI_Q30      = 64'sd3373259426;
	localparam logic signed [Z_W-1:0] HALF_PI_Z = 34'sd1686629713;

	// atan(2^-i) in Q30, truncated
	localparam logic [30:0] ATAN_Q30 [0:31] = '{
		31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158,
		31'd67021686,  31'd33543515,  31'd16775850,  31'd8388437,
		31'd4194282,   31'd2097149,   31'd1048575,   31'd524287,
		31'd262143,    31'd131071,    31'd65535,     31'd32767,
		31'd16383,     31'd8191,      31'd4095,      31'd2047,
		31'd1023,      31'd511,       31'd255,       31'd127,
		31'd63,        31'd31,        31'd15,        31'd7,
		31'd3,         31'd1,         31'd0,         31'd0
	};

	typedef struct packed {
		logic [RAD_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} atrp_sqrt_t;

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [Z_W-1:0]   z;
	} atrp_vec_t;

	typedef struct packed {
		logic smp;
		logic roll_zero;
		logic pitch_zero;
	} atrp_flags_t;

	// Turn a left-half-plane vector by +/- pi/2 so the CORDIC starts with x >= 0
	function automatic atrp_vec_t cordic_prep(input logic signed [VEC_W-1:0] y,
			input logic signed [VEC_W-1:0] x);
		atrp_vec_t v;
		v.x = x;
		v.y = y;
		v.z = '0;
		if (x < 0) begin
			if (y >= 0) begin
				v.x = y;
				v.y = -x;
				v.z = HALF_PI_Z;
			end else begin
				v.x = -y;
				v.y = x;
				v.z = -HALF_PI_Z;
			end
		end
		return v;
	endfunction

endpackage

@@ rtl/atrp_sqrt_cell.sv @@
// One cell of the integer square-root chain: settles one root bit per cycle while en is high.
`timescale 1ns / 1ps

module atrp_sqrt_cell #(
	parameter int BIT = 31,
	parameter int PW  = 49
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  vld_i,
	input  atrp_pkg::atrp_sqrt_t  st_i,
	input  logic [PW-1:0]         pay_i,
	output logic                  vld_o,
	output atrp_pkg::atrp_sqrt_t  st_o,
	output logic [PW-1:0]         pay_o
);

	localparam int RW = atrp_pkg::RAD_W;
	localparam int QW = atrp_pkg::ROOT_W;
	localparam int TW = RW + 2;

	logic [TW-1:0]          term;
	logic                   fits;
	atrp_pkg::atrp_sqrt_t   st_next;
	logic                   vld_q;
	atrp_pkg::atrp_sqrt_t   st_q;
	logic [PW-1:0]          pay_q;

	// Trial: (root + 2^BIT)^2 - root^2 = root * 2^(BIT+1) + 2^(2*BIT)
	assign term = (TW'(st_i.root) << (BIT + 1)) + (TW'(1) << (2 * BIT));
	assign fits = ({2'b00, st_i.rem} >= term);

	always_comb begin
		st_next = st_i;
		if (fits) begin
			st_next.rem  = st_i.rem - term[RW-1:0];
			st_next.root = st_i.root | (QW'(1) << BIT);
		end
	end

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	// Hold partial root and carried sample while stalled
	always_ff @(posedge clk) begin
		if (en) begin
			st_q  <= st_next;
			pay_q <= pay_i;
		end
	end

	assign vld_o = vld_q;
	assign st_o  = st_q;
	assign pay_o = pay_q;

endmodule

@@ rtl/atrp_cordic_cell.sv @@
// One vectoring CORDIC micro-rotation for the roll and pitch lanes side by side.
`timescale 1ns / 1ps

module atrp_cordic_cell #(
	parameter int K = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  vld_i,
	input  atrp_pkg::atrp_flags_t flags_i,
	input  atrp_pkg::atrp_vec_t   roll_i,
	input  atrp_pkg::atrp_vec_t   pitch_i,
	output logic                  vld_o,
	output atrp_pkg::atrp_flags_t flags_o,
	output atrp_pkg::atrp_vec_t   roll_o,
	output atrp_pkg::atrp_vec_t   pitch_o
);

	localparam int VW = atrp_pkg::VEC_W;
	localparam int ZW = atrp_pkg::Z_W;
	localparam logic signed [ZW-1:0] ATAN_Z = ZW'(atrp_pkg::ATAN_Q30[K]);

	logic                  vld_q;
	atrp_pkg::atrp_flags_t flags_q;
	atrp_pkg::atrp_vec_t   roll_q;
	atrp_pkg::atrp_vec_t   pitch_q;

	// Drive y towards zero, accumulating the angle turned
	function automatic atrp_pkg::atrp_vec_t rotate(input atrp_pkg::atrp_vec_t v);
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [VW-1:0] xs;
		logic signed [VW-1:0] ys;
		logic signed [ZW-1:0] z;
		atrp_pkg::atrp_vec_t  r;
		x  = v.x;
		y  = v.y;
		z  = v.z;
		xs = x >>> K;
		ys = y >>> K;
		if (!y[VW-1]) begin
			r.x = x + ys;
			r.y = y - xs;
			r.z = z + ATAN_Z;
		end else begin
			r.x = x - ys;
			r.y = y + xs;
			r.z = z - ATAN_Z;
		end
		return r;
	endfunction

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	// Advance both lanes
	always_ff @(posedge clk) begin
		if (en) begin
			flags_q <= flags_i;
			roll_q  <= rotate(roll_i);
			pitch_q <= rotate(pitch_i);
		end
	end

	assign vld_o   = vld_q;
	assign flags_o = flags_q;
	assign roll_o  = roll_q;
	assign pitch_o = pitch_q;

endmodule

@@ rtl/accel_tilt_roll_pitch.sv @@
// Top level: accelerometer sample in, roll and pitch angles out.
`timescale 1ns / 1ps

// Roll = atan2(y, z) and pitch = atan2(-x, sqrt(y^2 + z^2)) from one raw accelerometer
// sample, as signed radians with ANGLE_FRAC_BITS fraction bits, held to +/-pi and +/-pi/2.
// The block takes one sample per cycle while acc_ready is high and returns one beat
// per sample, in order; a sample flagged invalid comes back with result_valid low and
// both angles zero, and a zero vector gives zero angle. The stages, in order: squaring,
// summing, a 32-cell square-root chain, quadrant pre-rotation, one CORDIC cell per
// stage carrying both angles, rounding with saturation, and the output register. A
// one-beat skid register behind the output keeps acc_ready registered; the whole
// pipeline pauses only while that skid register is occupied.
module accel_tilt_roll_pitch #(
	parameter int SAMPLE_BITS     = 16,
	parameter int ANGLE_FRAC_BITS = 13,
	parameter int CORDIC_STAGES   = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              acc_valid,
	output logic                              acc_ready,
	input  logic                              sample_valid,
	input  logic signed [SAMPLE_BITS-1:0]     accel_x,
	input  logic signed [SAMPLE_BITS-1:0]     accel_y,
	input  logic signed [SAMPLE_BITS-1:0]     accel_z,
	output logic                              tilt_valid,
	input  logic                              tilt_ready,
	output logic                              result_valid,
	output logic signed [ANGLE_FRAC_BITS+2:0] roll_angle,
	output logic signed [ANGLE_FRAC_BITS+1:0] pitch_angle
);

	localparam int SB    = SAMPLE_BITS;
	localparam int RW    = ANGLE_FRAC_BITS + 3;
	localparam int PTW   = ANGLE_FRAC_BITS + 2;
	localparam int UP    = 32 - SAMPLE_BITS;
	localparam int RND   = 30 - ANGLE_FRAC_BITS;
	localparam int PAY_W = 3 * SAMPLE_BITS + 1;
	localparam int NSQ   = atrp_pkg::ROOT_W;
	localparam int CS    = CORDIC_STAGES;
	localparam int ZW    = atrp_pkg::Z_W;
	localparam int VW    = atrp_pkg::VEC_W;
	localparam int RADW  = atrp_pkg::RAD_W;

	localparam logic signed [ZW-1:0] RND_BIAS = ZW'(64'sd1 <<< (RND - 1));
	localparam logic signed [ZW-1:0] LIM_R =
		ZW'((atrp_pkg::PI_Q30 + (64'sd1 <<< (RND - 1))) >>> RND);
	localparam logic signed [ZW-1:0] LIM_P =
		ZW'(((atrp_pkg::PI_Q30 >>> 1) + (64'sd1 <<< (RND - 1))) >>> RND);

	logic en;

	// Stage registers
	logic                   vld_s1, vld_s2, vld_s3, vld_s4;
	logic                   smp_s1;
	logic signed [SB-1:0]   ax_s1, ay_s1, az_s1;
	logic [2*SB-1:0]        ysq_s1, zsq_s1;
	logic [RADW-1:0]        sq_s2;
	logic [PAY_W-1:0]       pay_s2;
	atrp_pkg::atrp_flags_t  flags_s3;
	atrp_pkg::atrp_vec_t    roll_s3, pitch_s3;
	logic                   res_s4;
	logic signed [RW-1:0]   roll_s4;
	logic signed [PTW-1:0]  pitch_s4;

	// Output and skid registers
	logic                   out_vld_q, skid_vld_q;
	logic                   out_res_q, skid_res_q;
	logic signed [RW-1:0]   out_roll_q, skid_roll_q;
	logic signed [PTW-1:0]  out_pitch_q, skid_pitch_q;
	logic                   out_free;

	// Combinational helpers
	logic signed [2*SB-1:0] ysq, zsq;
	logic [2*SB:0]          sq_sum;
	logic                   smp_p;
	logic signed [SB-1:0]   ax_p, ay_p, az_p;
	logic signed [VW-1:0]   axw, ayw, azw, rw;
	logic                   rzero_p;
	logic signed [ZW-1:0]   zr_rnd, zp_rnd, zr_ang, zp_ang, zr_sat, zp_sat;
	atrp_pkg::atrp_flags_t  fl_e;

	// Chains
	logic                   sq_vld [0:NSQ];
	atrp_pkg::atrp_sqrt_t   sq_st  [0:NSQ];
	logic [PAY_W-1:0]       sq_pay [0:NSQ];
	logic                   cd_vld   [0:CS];
	atrp_pkg::atrp_flags_t  cd_flags [0:CS];
	atrp_pkg::atrp_vec_t    cd_roll  [0:CS];
	atrp_pkg::atrp_vec_t    cd_pitch [0:CS];

	// Advance the pipeline unless the skid register holds a beat
	assign en        = ~skid_vld_q;
	assign acc_ready = en;

	// Squares and the sum of squares, scaled as if the axes were 32 bits wide
	assign ysq    = accel_y * accel_y;
	assign zsq    = accel_z * accel_z;
	assign sq_sum = {1'b0, ysq_s1} + {1'b0, zsq_s1};

	// Unpack the carried sample at the end of the root chain and prescale
	assign {smp_p, ax_p, ay_p, az_p} = sq_pay[NSQ];
	assign axw     = VW'(ax_p) <<< (UP + atrp_pkg::PRESCALE);
	assign ayw     = VW'(ay_p) <<< (UP + atrp_pkg::PRESCALE);
	assign azw     = VW'(az_p) <<< (UP + atrp_pkg::PRESCALE);
	assign rw      = VW'(sq_st[NSQ].root) << atrp_pkg::PRESCALE;
	assign rzero_p = (ay_p == '0) && (az_p == '0);

	// Round Q30 to the output scale and clamp
	assign fl_e   = cd_flags[CS];
	assign zr_rnd = cd_roll[CS].z + RND_BIAS;
	assign zp_rnd = cd_pitch[CS].z + RND_BIAS;
	assign zr_ang = zr_rnd >>> RND;
	assign zp_ang = zp_rnd >>> RND;
	assign zr_sat = (zr_ang > LIM_R) ? LIM_R : ((zr_ang < -LIM_R) ? -LIM_R : zr_ang);
	assign zp_sat = (zp_ang > LIM_P) ? LIM_P : ((zp_ang < -LIM_P) ? -LIM_P : zp_ang);

	// Stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= acc_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= sq_vld[NSQ];
			vld_s4 <= cd_vld[CS];
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (en) begin
			smp_s1   <= sample_valid;
			ax_s1    <= accel_x;
			ay_s1    <= accel_y;
			az_s1    <= accel_z;
			ysq_s1   <= $unsigned(ysq);
			zsq_s1   <= $unsigned(zsq);
			sq_s2    <= RADW'(sq_sum) << (2 * UP);
			pay_s2   <= {smp_s1, ax_s1, ay_s1, az_s1};
			flags_s3 <= '{smp: smp_p, roll_zero: rzero_p,
				pitch_zero: rzero_p && (ax_p == '0)};
			roll_s3  <= atrp_pkg::cordic_prep(ayw, azw);
			pitch_s3 <= atrp_pkg::cordic_prep(-axw, rw);
			res_s4   <= fl_e.smp;
			roll_s4  <= (!fl_e.smp || fl_e.roll_zero) ? '0 : RW'(zr_sat);
			pitch_s4 <= (!fl_e.smp || fl_e.pitch_zero) ? '0 : PTW'(zp_sat);
		end
	end

	// Square-root chain, most significant root bit first
	assign sq_vld[0] = vld_s2;
	assign sq_st[0]  = '{rem: sq_s2, root: '0};
	assign sq_pay[0] = pay_s2;

	for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
		atrp_sqrt_cell #(
			.BIT (NSQ - 1 - i),
			.PW  (PAY_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (sq_vld[i]),
			.st_i   (sq_st[i]),
			.pay_i  (sq_pay[i]),
			.vld_o  (sq_vld[i+1]),
			.st_o   (sq_st[i+1]),
			.pay_o  (sq_pay[i+1])
		);
	end

	// CORDIC chain, both angles in lockstep
	assign cd_vld[0]   = vld_s3;
	assign cd_flags[0] = flags_s3;
	assign cd_roll[0]  = roll_s3;
	assign cd_pitch[0] = pitch_s3;

	for (genvar i = 0; i < CS; i++) begin : g_cordic
		atrp_cordic_cell #(
			.K (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld_i   (cd_vld[i]),
			.flags_i (cd_flags[i]),
			.roll_i  (cd_roll[i]),
			.pitch_i (cd_pitch[i]),
			.vld_o   (cd_vld[i+1]),
			.flags_o (cd_flags[i+1]),
			.roll_o  (cd_roll[i+1]),
			.pitch_o (cd_pitch[i+1])
		);
	end

	// Output register with skid behind it
	assign out_free = ~out_vld_q | tilt_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_vld_q <= skid_vld_q | vld_s4;
			end
			if (skid_vld_q && out_free) begin
				skid_vld_q <= 1'b0;
			end else if (!skid_vld_q && vld_s4 && !out_free) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_vld_q) begin
				out_res_q   <= skid_res_q;
				out_roll_q  <= skid_roll_q;
				out_pitch_q <= skid_pitch_q;
			end else begin
				out_res_q   <= res_s4;
				out_roll_q  <= roll_s4;
				out_pitch_q <= pitch_s4;
			end
		end
		if (!skid_vld_q && vld_s4 && !out_free) begin
			skid_res_q   <= res_s4;
			skid_roll_q  <= roll_s4;
			skid_pitch_q <= pitch_s4;
		end
	end

	assign tilt_valid   = out_vld_q;
	assign result_valid = out_res_q;
	assign roll_angle   = out_roll_q;
	assign pitch_angle  = out_pitch_q;

	// The skid register only holds a beat behind an occupied output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid register occupied while output register empty");

	// The skid register fills only from a stalled output
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !tilt_ready))
		else $error("skid register filled without an output stall");

	// Invalid samples come out with both angles zero
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(tilt_valid && !result_valid) |-> (roll_angle == '0) && (pitch_angle == '0))
		else $error("non-zero angle on an invalid sample");

	// Angles stay inside their clamps
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		tilt_valid |-> (roll_angle <= LIM_R) && (roll_angle >= -LIM_R) &&
			(pitch_angle <= LIM_P) && (pitch_angle >= -LIM_P))
		else $error("angle outside saturation limits");

endmodule

@@ dv/accel_tilt_roll_pitch_tb.sv @@
// Self-checking testbench for the accelerometer roll and pitch pipeline.
`timescale 1ns / 1ps

module accel_tilt_roll_pitch_tb;

	localparam int  FRAC          = 13;
	localparam int  STAGES        = 16;
	localparam int  CALM_ITEMS    = 200;
	localparam int  RANDOM_ITEMS  = 1200;
	localparam int  SETTLE_CYCLES = 80;
	localparam int  CYCLE_LIMIT   = 200000;

	// Angles in Q30 and the rounded output limits
	localparam longint PI_Q30_C   = 64'sd3373259426;
	localparam longint HALF_PI_C  = 64'sd1686629713;
	localparam int     DROP_BITS  = 30 - FRAC;
	localparam longint ROLL_LIM   = (PI_Q30_C + (64'sd1 <<< (DROP_BITS - 1))) >>> DROP_BITS;
	localparam longint PITCH_LIM  = (HALF_PI_C + (64'sd1 <<< (DROP_BITS - 1))) >>> DROP_BITS;

	// atan(2^-i) in Q30, truncated
	localparam longint ATAN_STEP [0:15] = '{
		843314856, 497837829, 263043836, 133525158,
		67021686,  33543515,  16775850,  8388437,
		4194282,   2097149,   1048575,   524287,
		262143,    131071,    65535,     32767
	};

	localparam logic signed [15:0] AXIS_EDGES [0:5] = '{
		-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767
	};

	typedef struct {
		bit                 sv;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		bit                 drain;
	} sample_t;

	typedef struct packed {
		logic                     valid;
		logic signed [FRAC+2:0]   roll;
		logic signed [FRAC+1:0]   pitch;
	} tilt_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   acc_valid = 1'b0;
	logic                   acc_ready;
	logic                   sample_valid = 1'b0;
	logic signed [15:0]     accel_x = '0;
	logic signed [15:0]     accel_y = '0;
	logic signed [15:0]     accel_z = '0;
	logic                   tilt_valid;
	logic                   tilt_ready = 1'b0;
	logic                   result_valid;
	logic signed [FRAC+2:0] roll_angle;
	logic signed [FRAC+1:0] pitch_angle;

	sample_t sample_q[$];
	tilt_t   tilt_exp[$];
	bit      beat_in = 1'b0;
	int      gap_left = 0;
	int      stall_left = 0;
	int      n_in = 0;
	int      n_out = 0;
	int      n_invalid = 0;
	int      n_drains = 0;
	int      fail_count = 0;
	int      cycle_count = 0;

	accel_tilt_roll_pitch dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.acc_valid    (acc_valid),
		.acc_ready    (acc_ready),
		.sample_valid (sample_valid),
		.accel_x      (accel_x),
		.accel_y      (accel_y),
		.accel_z      (accel_z),
		.tilt_valid   (tilt_valid),
		.tilt_ready   (tilt_ready),
		.result_valid (result_valid),
		.roll_angle   (roll_angle),
		.pitch_angle  (pitch_angle)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Vectoring CORDIC: atan2(y, x) in Q30
	function automatic longint atan2_q30(longint y, longint x);
		longint ang;
		longint t;
		longint xs;
		longint ys;
		ang = 0;
		if (x == 0 && y == 0)
			return 0;
		// fold the left half-plane onto the right one
		if (x < 0) begin
			if (y >= 0) begin
				t = y;
				y = -x;
				x = t;
				ang = HALF_PI_C;
			end else begin
				t = -y;
				y = x;
				x = t;
				ang = -HALF_PI_C;
			end
		end
		x = x * (64'sd1 <<< 27);
		y = y * (64'sd1 <<< 27);
		for (int i = 0; i < STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				ang = ang + ATAN_STEP[i];
			end else begin
				x = x - ys;
				y = y + xs;
				ang = ang - ATAN_STEP[i];
			end
		end
		return ang;
	endfunction

	// Round Q30 half up to the output fraction, then clamp to +/- lim
	function automatic longint q30_to_angle(longint q, longint lim);
		longint a;
		a = (q + (64'sd1 <<< (DROP_BITS - 1))) >>> DROP_BITS;
		if (a > lim)
			a = lim;
		if (a < -lim)
			a = -lim;
		return a;
	endfunction

	function automatic tilt_t tilt_predict(bit sv, logic signed [15:0] x,
			logic signed [15:0] y, logic signed [15:0] z);
		tilt_t             r;
		longint            ax;
		longint            ay;
		longint            az;
		longint            ang;
		longint unsigned   rad;
		longint unsigned   root;
		longint unsigned   bitv;
		r = '0;
		r.valid = sv;
		if (sv) begin
			ax = longint'(x) * 65536;
			ay = longint'(y) * 65536;
			az = longint'(z) * 65536;
			rad = longint'(ay * ay) + longint'(az * az);
			// exact integer square root of the radicand
			root = 0;
			bitv = 64'd1 << 62;
			while (bitv > rad)
				bitv = bitv >> 2;
			while (bitv != 0) begin
				if (rad >= root + bitv) begin
					rad = rad - (root + bitv);
					root = (root >> 1) + bitv;
				end else begin
					root = root >> 1;
				end
				bitv = bitv >> 2;
			end
			ang = q30_to_angle(atan2_q30(ay, az), ROLL_LIM);
			r.roll = ang[FRAC+2:0];
			ang = q30_to_angle(atan2_q30(-ax, longint'(root)), PITCH_LIM);
			r.pitch = ang[FRAC+1:0];
		end
		return r;
	endfunction

	task automatic add_sample(bit sv, int x, int y, int z, bit drain);
		sample_t s;
		s.sv = sv;
		s.x = 16'(x);
		s.y = 16'(y);
		s.z = 16'(z);
		s.drain = drain;
		sample_q.push_back(s);
	endtask

	// Mostly full-range counts, with small values and edge values mixed in
	function automatic logic signed [15:0] rand_axis();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return 16'($urandom);
			6, 7:             return 16'(int'($urandom_range(0, 16)) - 8);
			default:          return AXIS_EDGES[$urandom_range(0, 5)];
		endcase
	endfunction

	// Source side: present queued samples, with idle bursts until the calm tail
	always @(negedge clk) begin
		sample_t s;
		logic    nv;
		nv = acc_valid && !beat_in;
		if (arst_n && !nv) begin
			if (gap_left != 0) begin
				gap_left = gap_left - 1;
			end else if (sample_q.size() > CALM_ITEMS && $urandom_range(0, 9) == 0) begin
				gap_left = $urandom_range(0, 3);
			end else if (sample_q.size() != 0 &&
					!(sample_q[0].drain && tilt_exp.size() != 0)) begin
				s = sample_q.pop_front();
				if (s.drain)
					n_drains++;
				nv = 1'b1;
				sample_valid <= s.sv;
				accel_x <= s.x;
				accel_y <= s.y;
				accel_z <= s.z;
			end
		end
		acc_valid <= nv;
	end

	// Sink side: drop ready in random bursts until the calm tail
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left = stall_left - 1;
			tilt_ready <= 1'b0;
		end else if (sample_q.size() > CALM_ITEMS && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 3);
			tilt_ready <= 1'b0;
		end else begin
			tilt_ready <= 1'b1;
		end
	end

	// Predict each accepted sample and check each result beat in order
	always @(posedge clk) begin
		tilt_t want;
		if (!arst_n) begin
			beat_in <= 1'b0;
		end else begin
			beat_in <= acc_valid && acc_ready;
			if (acc_valid && acc_ready) begin
				tilt_exp.push_back(tilt_predict(sample_valid, accel_x, accel_y, accel_z));
				n_in++;
				if (!sample_valid)
					n_invalid++;
			end
			if (tilt_valid && tilt_ready) begin
				n_out++;
				if (tilt_exp.size() == 0) begin
					$error("unexpected tilt beat: roll %0d pitch %0d", roll_angle, pitch_angle);
					fail_count++;
				end else begin
					want = tilt_exp.pop_front();
					if (result_valid !== want.valid) begin
						$error("result_valid: expected %0d, got %0d", want.valid, result_valid);
						fail_count++;
					end
					if (roll_angle !== want.roll) begin
						$error("roll_angle: expected %0d, got %0d", want.roll, roll_angle);
						fail_count++;
					end
					if (pitch_angle !== want.pitch) begin
						$error("pitch_angle: expected %0d, got %0d", want.pitch, pitch_angle);
						fail_count++;
					end
				end
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk) cycle_count++;
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		bit                 sv;

		// Directed: invalid flag, zero vectors, axis extremes, all quadrants
		add_sample(0, 12345, -2222, 333, 0);
		add_sample(0, -32768, -32768, -32768, 0);
		add_sample(1, 0, 0, 0, 0);
		add_sample(1, 1000, 0, 0, 0);
		add_sample(1, -32768, 0, 0, 0);
		add_sample(1, 32767, 0, 0, 0);
		add_sample(1, -32768, -32768, -32768, 0);
		add_sample(1, 32767, 32767, 32767, 0);
		add_sample(1, 5, 0, -1, 0);
		add_sample(1, -5, 0, -32768, 0);
		add_sample(1, 0, -1, -32768, 0);
		add_sample(1, 0, 1, -32768, 0);
		add_sample(1, 0, -1, -1, 0);
		add_sample(1, 0, 1, -1, 0);
		add_sample(1, 0, 32767, 0, 0);
		add_sample(1, 0, -32768, 0, 0);
		add_sample(1, -32768, 0, 1, 0);
		add_sample(1, 32767, 1, 0, 0);
		add_sample(1, 1, 0, 1, 0);
		add_sample(1, -1, 32767, -32768, 0);
		add_sample(1, 16384, -16384, 16384, 0);

		// Random: hold off once after the directed part and once midway
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			sv = ($urandom_range(0, 9) != 0);
			x = rand_axis();
			y = rand_axis();
			z = rand_axis();
			if ($urandom_range(0, 15) == 0) begin
				y = '0;
				z = '0;
				if ($urandom_range(0, 2) == 0)
					x = '0;
			end
			add_sample(sv, x, y, z, (i == 0) || (i == RANDOM_ITEMS / 2));
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (sample_q.size() != 0 || acc_valid)
			@(posedge clk);
		while (tilt_exp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d samples (%0d flagged invalid), checked %0d tilt beats.",
			n_in, n_invalid, n_out);
		$display("Random stalls on both channels; %0d full drains of the pipeline.", n_drains);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ accel_tilt_roll_pitch.f @@
rtl/atrp_pkg.sv
rtl/atrp_sqrt_cell.sv
rtl/atrp_cordic_cell.sv
rtl/accel_tilt_roll_pitch.sv
dv/accel_tilt_roll_pitch_tb.sv
